// File: src/fsp_pkg.sv
// Package for the five-stage pipeline core: opcodes, the noop word and
// instruction field decode functions. No dependencies.
package fsp_pkg;

  localparam int unsigned REGISTER_COUNT = 8;
  localparam int unsigned RegAw          = 3;
  localparam logic [31:0] NOOP_WORD      = 32'h01c0_0000;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_NAND = 3'd1;
  localparam logic [2:0] OP_LW   = 3'd2;
  localparam logic [2:0] OP_SW   = 3'd3;
  localparam logic [2:0] OP_BEQ  = 3'd4;
  localparam logic [2:0] OP_CMOV = 3'd5;
  localparam logic [2:0] OP_HALT = 3'd6;

  typedef struct packed {
    logic             en;
    logic [RegAw-1:0] r;
  } dest_t;

  function automatic logic [2:0] op_of(input logic [31:0] w);
    op_of = w[24:22];
  endfunction

  function automatic logic [RegAw-1:0] ra_of(input logic [31:0] w);
    ra_of = w[21:19];
  endfunction

  function automatic logic [RegAw-1:0] rb_of(input logic [31:0] w);
    rb_of = w[18:16];
  endfunction

  function automatic dest_t dest_of(input logic [31:0] w, input logic allow_lw);
    dest_t d;
    d.en = 1'b0;
    d.r  = w[2:0];
    if (w[24:22] == OP_ADD || w[24:22] == OP_NAND || w[24:22] == OP_CMOV) begin
      d.en = 1'b1;
    end else if (allow_lw && w[24:22] == OP_LW) begin
      d.en = 1'b1;
      d.r  = w[18:16];
    end
    dest_of = d;
  endfunction

  // A result is only forwarded to a nonzero register that matches.
  function automatic logic fwd_hit(input dest_t d, input logic [RegAw-1:0] want);
    fwd_hit = d.en && (d.r != '0) && (d.r == want);
  endfunction

endpackage

// File: src/fsp_if.sv
// Handshake interfaces for the five-stage pipeline core: the item channel
// and the result channel. Depends on nothing.
interface fsp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] load_address;
  logic [31:0] load_data;
  modport source (output valid, operation, load_address, load_data, input ready);
  modport sink (input valid, operation, load_address, load_data, output ready);
endinterface

interface fsp_out_if;
  logic        valid;
  logic        ready;
  logic        halted;
  logic [31:0] cycle_count;
  logic [15:0] program_counter_out;
  logic        writeback_valid;
  logic [2:0]  writeback_register;
  logic [31:0] writeback_value;
  logic        store_valid;
  logic [15:0] store_address;
  logic [31:0] store_value;
  modport source (output valid, halted, cycle_count, program_counter_out,
    writeback_valid, writeback_register, writeback_value, store_valid,
    store_address, store_value, input ready);
  modport sink (input valid, halted, cycle_count, program_counter_out,
    writeback_valid, writeback_register, writeback_value, store_valid,
    store_address, store_value, output ready);
endinterface

// File: src/fsp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address being written returns the old contents.
module fsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/five_stage_pipeline_core.sv
// Five-stage pipelined core. One item per cycle while no result is stalled;
// its result is registered at the output on the transfer. Instruction and
// data stores and two register file copies are RAMs, read ahead with bypass.
// Reset (synchronous) clears the pipeline to noops, the PC, the cycle count
// and the register file valid bits; the stores are undefined until written.
// Depends on fsp_pkg, fsp_if and fsp_ram.
module five_stage_pipeline_core #(
  parameter int unsigned MEMORY_WORDS = 65536
) (
  input logic      clk,
  input logic      rst,
  fsp_in_if.sink   items,
  fsp_out_if.source results
);
  localparam int unsigned Aw = $clog2(MEMORY_WORDS);
  localparam int unsigned Rw = fsp_pkg::RegAw;

  logic [15:0] pc, pc_next;
  logic [31:0] cycles, cycles_next;
  logic [31:0] fd_word, fd_word_next;
  logic [15:0] fd_pc, fd_pc_next;
  logic [31:0] de_word, de_word_next, de_a, de_a_next, de_b, de_b_next;
  logic [15:0] de_pc, de_pc_next, de_off, de_off_next;
  logic [31:0] em_word, em_word_next, em_result, em_result_next, em_b, em_b_next;
  logic [15:0] em_target, em_target_next;
  logic [31:0] mw_word, mw_word_next, mw_value, mw_value_next;
  logic [31:0] we_word, we_word_next, we_value, we_value_next;
  logic [fsp_pkg::REGISTER_COUNT-1:0] rf_valid;

  logic accept, load, step, halted;
  assign items.ready = !rst && (!results.valid || results.ready);
  assign accept = items.valid && items.ready;
  assign halted = fsp_pkg::op_of(mw_word) == fsp_pkg::OP_HALT;
  assign load = accept && !items.operation;
  assign step = accept && items.operation && !halted;

  // Instruction store
  logic [Aw-1:0] i_raddr;
  logic [31:0]   i_rdata, i_wq, fetch_word;
  logic          i_hit;
  assign i_raddr = rst ? '0 : pc_next[Aw-1:0];
  fsp_ram #(.WIDTH(32), .DEPTH(MEMORY_WORDS)) u_imem (
    .clk, .we(load), .waddr(items.load_address[Aw-1:0]), .wdata(items.load_data),
    .raddr(i_raddr), .rdata(i_rdata));
  always_ff @(posedge clk) begin
    i_hit <= load && (items.load_address[Aw-1:0] == i_raddr);
    i_wq  <= items.load_data;
  end
  assign fetch_word = i_hit ? i_wq : i_rdata;

  // Data store
  logic          d_we, d_hit, sw_now;
  logic [Aw-1:0] d_waddr, d_raddr;
  logic [31:0]   d_wdata, d_rdata, d_wq, lw_word;
  assign sw_now  = step && fsp_pkg::op_of(em_word) == fsp_pkg::OP_SW;
  assign d_we    = load || sw_now;
  assign d_waddr = load ? items.load_address[Aw-1:0] : em_result[Aw-1:0];
  assign d_wdata = load ? items.load_data : em_b;
  assign d_raddr = em_result_next[Aw-1:0];
  fsp_ram #(.WIDTH(32), .DEPTH(MEMORY_WORDS)) u_dmem (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr),
    .rdata(d_rdata));
  always_ff @(posedge clk) begin
    d_hit <= d_we && (d_waddr == d_raddr);
    d_wq  <= d_wdata;
  end
  assign lw_word = d_hit ? d_wq : d_rdata;

  // Register file, one copy per read port
  fsp_pkg::dest_t wb_dest;
  logic          rf_we;
  logic [Rw-1:0] ra_addr, rb_addr;
  logic [31:0]   ra_rdata, rb_rdata, ra_wq, rb_wq, rf_a, rf_b;
  logic          ra_hit, rb_hit, ra_vld, rb_vld;
  assign wb_dest = fsp_pkg::dest_of(mw_word, 1'b1);
  assign rf_we   = step && wb_dest.en;
  assign ra_addr = fsp_pkg::ra_of(fd_word_next);
  assign rb_addr = fsp_pkg::rb_of(fd_word_next);
  fsp_ram #(.WIDTH(32), .DEPTH(fsp_pkg::REGISTER_COUNT)) u_rfa (
    .clk, .we(rf_we), .waddr(wb_dest.r), .wdata(mw_value), .raddr(ra_addr),
    .rdata(ra_rdata));
  fsp_ram #(.WIDTH(32), .DEPTH(fsp_pkg::REGISTER_COUNT)) u_rfb (
    .clk, .we(rf_we), .waddr(wb_dest.r), .wdata(mw_value), .raddr(rb_addr),
    .rdata(rb_rdata));
  always_ff @(posedge clk) begin
    ra_wq <= mw_value;
    rb_wq <= mw_value;
    if (rst) begin
      rf_valid <= '0;
      ra_hit   <= 1'b0;
      rb_hit   <= 1'b0;
      ra_vld   <= 1'b0;
      rb_vld   <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_valid[wb_dest.r] <= 1'b1;
      end
      ra_hit <= rf_we && (wb_dest.r == ra_addr);
      rb_hit <= rf_we && (wb_dest.r == rb_addr);
      ra_vld <= rf_valid[ra_addr];
      rb_vld <= rf_valid[rb_addr];
    end
  end
  assign rf_a = ra_hit ? ra_wq : (ra_vld ? ra_rdata : '0);
  assign rf_b = rb_hit ? rb_wq : (rb_vld ? rb_rdata : '0);

  // Pipeline next state
  fsp_pkg::dest_t em_dest, mw_dest, we_dest;
  logic [31:0] fa, fb, off_ext;
  logic [Rw-1:0] ex_ra, ex_rb;
  logic stall, taken;
  assign em_dest = fsp_pkg::dest_of(em_word, 1'b0);
  assign mw_dest = wb_dest;
  assign we_dest = fsp_pkg::dest_of(we_word, 1'b1);
  assign ex_ra   = fsp_pkg::ra_of(de_word);
  assign ex_rb   = fsp_pkg::rb_of(de_word);
  assign off_ext = {{16{de_off[15]}}, de_off};

  always_comb begin
    fa = de_a;
    if (fsp_pkg::fwd_hit(em_dest, ex_ra)) begin
      fa = em_result;
    end else if (fsp_pkg::fwd_hit(mw_dest, ex_ra)) begin
      fa = mw_value;
    end else if (fsp_pkg::fwd_hit(we_dest, ex_ra)) begin
      fa = we_value;
    end
    fb = de_b;
    if (fsp_pkg::fwd_hit(em_dest, ex_rb)) begin
      fb = em_result;
    end else if (fsp_pkg::fwd_hit(mw_dest, ex_rb)) begin
      fb = mw_value;
    end else if (fsp_pkg::fwd_hit(we_dest, ex_rb)) begin
      fb = we_value;
    end
  end

  assign stall = fsp_pkg::op_of(de_word) == fsp_pkg::OP_LW &&
    (fsp_pkg::rb_of(de_word) == fsp_pkg::ra_of(fd_word) ||
     fsp_pkg::rb_of(de_word) == fsp_pkg::rb_of(fd_word));
  assign taken = fsp_pkg::op_of(em_word) == fsp_pkg::OP_BEQ && em_result == 32'd1;

  always_comb begin
    pc_next = pc;
    cycles_next = cycles;
    fd_word_next = fd_word;
    fd_pc_next = fd_pc;
    de_word_next = de_word;
    de_pc_next = de_pc;
    de_a_next = de_a;
    de_b_next = de_b;
    de_off_next = de_off;
    em_word_next = em_word;
    em_target_next = em_target;
    em_result_next = em_result;
    em_b_next = em_b;
    mw_word_next = mw_word;
    mw_value_next = mw_value;
    we_word_next = we_word;
    we_value_next = we_value;
    if (step) begin
      cycles_next = cycles + 32'd1;
      if (stall) begin
        de_word_next = fsp_pkg::NOOP_WORD;
      end else begin
        fd_word_next = fetch_word;
        fd_pc_next = pc + 16'd1;
        pc_next = pc + 16'd1;
        de_word_next = fd_word;
      end
      de_pc_next = fd_pc;
      de_a_next = rf_a;
      de_b_next = rf_b;
      de_off_next = fd_word[15:0];

      em_word_next = de_word;
      em_b_next = fb;
      em_target_next = de_pc + de_off;
      case (fsp_pkg::op_of(de_word))
        fsp_pkg::OP_ADD: em_result_next = fa + fb;
        fsp_pkg::OP_NAND: em_result_next = ~(fa & fb);
        fsp_pkg::OP_CMOV: begin
          if (fb != '0) begin
            em_result_next = fa;
          end else begin
            em_word_next = fsp_pkg::NOOP_WORD;
          end
        end
        fsp_pkg::OP_LW, fsp_pkg::OP_SW: em_result_next = fa + off_ext;
        fsp_pkg::OP_BEQ: em_result_next = {31'd0, fa == fb};
        default: em_result_next = em_result;
      endcase

      mw_word_next = em_word;
      case (fsp_pkg::op_of(em_word))
        fsp_pkg::OP_ADD, fsp_pkg::OP_NAND, fsp_pkg::OP_CMOV: mw_value_next = em_result;
        fsp_pkg::OP_LW: mw_value_next = lw_word;
        default: mw_value_next = mw_value;
      endcase
      if (taken) begin
        fd_word_next = fsp_pkg::NOOP_WORD;
        de_word_next = fsp_pkg::NOOP_WORD;
        em_word_next = fsp_pkg::NOOP_WORD;
        pc_next = em_target;
      end

      we_word_next = mw_word;
      we_value_next = mw_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      cycles <= '0;
      fd_word <= fsp_pkg::NOOP_WORD;
      de_word <= fsp_pkg::NOOP_WORD;
      em_word <= fsp_pkg::NOOP_WORD;
      mw_word <= fsp_pkg::NOOP_WORD;
      we_word <= fsp_pkg::NOOP_WORD;
      fd_pc <= '0;
      de_pc <= '0;
      de_a <= '0;
      de_b <= '0;
      de_off <= '0;
      em_target <= '0;
      em_result <= '0;
      em_b <= '0;
      mw_value <= '0;
      we_value <= '0;
    end else begin
      pc <= pc_next;
      cycles <= cycles_next;
      fd_word <= fd_word_next;
      de_word <= de_word_next;
      em_word <= em_word_next;
      mw_word <= mw_word_next;
      we_word <= we_word_next;
      fd_pc <= fd_pc_next;
      de_pc <= de_pc_next;
      de_a <= de_a_next;
      de_b <= de_b_next;
      de_off <= de_off_next;
      em_target <= em_target_next;
      em_result <= em_result_next;
      em_b <= em_b_next;
      mw_value <= mw_value_next;
      we_value <= we_value_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (accept) begin
      results.halted <= halted;
      results.cycle_count <= cycles_next;
      results.program_counter_out <= pc_next;
      results.writeback_valid <= rf_we;
      results.writeback_register <= rf_we ? wb_dest.r : '0;
      results.writeback_value <= rf_we ? mw_value : '0;
      results.store_valid <= sw_now;
      results.store_address <= sw_now ? {{(16-Aw){1'b0}}, em_result[Aw-1:0]} : '0;
      results.store_value <= sw_now ? em_b : '0;
    end
  end
endmodule

// File: src/fsp_checker.sv
// Port-level checks for the five-stage pipeline core, bound to its top level.
// Depends on five_stage_pipeline_core and fsp_if.
module fsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_cycle,
  input logic        wb_valid,
  input logic [2:0]  wb_reg,
  input logic [31:0] wb_value,
  input logic        st_valid,
  input logic [15:0] st_addr,
  input logic [31:0] st_value
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_cycle)) else $error("result changed while stalled");
  a_wb_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !wb_valid |-> wb_reg == 3'd0 && wb_value == 32'd0)
    else $error("writeback fields set without a write");
  a_st_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !st_valid |-> st_addr == 16'd0 && st_value == 32'd0)
    else $error("store fields set without a store");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");
endmodule

bind five_stage_pipeline_core fsp_checker u_fsp_checker (
  .clk(clk), .rst(rst), .out_valid(results.valid), .out_ready(results.ready),
  .out_cycle(results.cycle_count), .wb_valid(results.writeback_valid),
  .wb_reg(results.writeback_register), .wb_value(results.writeback_value),
  .st_valid(results.store_valid), .st_addr(results.store_address),
  .st_value(results.store_value));

// File: verif/testbench.sv
// Self-checking testbench for five_stage_pipeline_core: loads programs, steps the pipeline
// and checks each result against a cycle-accurate predictor of the core.
// Depends on fsp_pkg, fsp_if and the core RTL.
module testbench;

  typedef struct packed {
    logic        halted;
    logic [31:0] cycle_count;
    logic [15:0] pc;
    logic        wb_valid;
    logic [2:0]  wb_reg;
    logic [31:0] wb_value;
    logic        st_valid;
    logic [15:0] st_addr;
    logic [31:0] st_value;
  } core_result_t;

  class core_scoreboard;
    logic [31:0] imem[int];
    logic [31:0] dmem[int];
    logic [31:0] rf[8];
    logic [15:0] pc, fd_pc, de_pc, de_off, em_target;
    logic [31:0] fd_word, de_word, de_a, de_b, em_word, em_result, em_b;
    logic [31:0] mw_word, mw_value, we_word, we_value, cycles;
    core_result_t pending[$];
    int errors, writebacks, stores;

    function new();
      foreach (rf[k]) rf[k] = '0;
      pc = '0; fd_pc = '0; de_pc = '0; de_off = '0; em_target = '0;
      fd_word = fsp_pkg::NOOP_WORD; de_word = fsp_pkg::NOOP_WORD;
      em_word = fsp_pkg::NOOP_WORD;
      mw_word = fsp_pkg::NOOP_WORD; we_word = fsp_pkg::NOOP_WORD;
      de_a = '0; de_b = '0; em_result = '0; em_b = '0;
      mw_value = '0; we_value = '0; cycles = '0;
      errors = 0; writebacks = 0; stores = 0;
    endfunction

    function logic [31:0] fetch_word(logic [31:0] addr);
      return imem.exists(int'(addr[15:0])) ? imem[int'(addr[15:0])] : '0;
    endfunction

    function logic [31:0] data_word(logic [31:0] addr);
      return dmem.exists(int'(addr[15:0])) ? dmem[int'(addr[15:0])] : '0;
    endfunction

    // Destination register of a word, or 8 when it writes none.
    function logic [3:0] dest_reg(logic [31:0] w, bit with_lw);
      if (w[24:22] == fsp_pkg::OP_ADD || w[24:22] == fsp_pkg::OP_NAND ||
          w[24:22] == fsp_pkg::OP_CMOV) begin
        return {1'b0, w[2:0]};
      end
      if (with_lw && w[24:22] == fsp_pkg::OP_LW) begin
        return {1'b0, w[18:16]};
      end
      return 4'd8;
    endfunction

    function void note(logic operation, logic [15:0] addr, logic [31:0] data);
      core_result_t r;
      logic [3:0] dsts[3];
      logic [31:0] vals[3];
      logic [31:0] a, b, sext_off;
      logic [3:0] d;
      bit ta, tb;
      logic [31:0] n_fd_word, n_de_word, n_em_word, n_em_result, wb_src;
      logic [31:0] n_de_a, n_de_b;
      logic [15:0] n_pc, n_fd_pc;
      r = '0;
      r.halted = (mw_word[24:22] == fsp_pkg::OP_HALT);
      if (!operation) begin
        imem[int'(addr)] = data;
        dmem[int'(addr)] = data;
      end else if (!r.halted) begin
        cycles = cycles + 1;
        n_fd_word = fetch_word({16'h0, pc});
        n_fd_pc = pc + 16'd1;
        n_pc = n_fd_pc;
        n_de_word = fd_word;
        if (de_word[24:22] == fsp_pkg::OP_LW &&
            (de_word[18:16] == fd_word[21:19] || de_word[18:16] == fd_word[18:16])) begin
          n_fd_word = fd_word;
          n_fd_pc = fd_pc;
          n_de_word = fsp_pkg::NOOP_WORD;
          n_pc = pc;
        end
        // Decode reads the register file as it stood before this cycle's writeback.
        n_de_a = rf[fd_word[21:19]];
        n_de_b = rf[fd_word[18:16]];
        a = de_a;
        b = de_b;
        ta = 0;
        tb = 0;
        dsts[0] = dest_reg(em_word, 0); vals[0] = em_result;
        dsts[1] = dest_reg(mw_word, 1); vals[1] = mw_value;
        dsts[2] = dest_reg(we_word, 1); vals[2] = we_value;
        for (int k = 0; k < 3; k++) begin
          if (dsts[k] != 4'd8 && dsts[k] != 4'd0) begin
            if (!ta && dsts[k][2:0] == de_word[21:19]) begin
              a = vals[k];
              ta = 1;
            end
            if (!tb && dsts[k][2:0] == de_word[18:16]) begin
              b = vals[k];
              tb = 1;
            end
          end
        end
        sext_off = {{16{de_off[15]}}, de_off};
        n_em_word = de_word;
        n_em_result = em_result;
        case (de_word[24:22])
          fsp_pkg::OP_ADD: n_em_result = a + b;
          fsp_pkg::OP_NAND: n_em_result = ~(a & b);
          fsp_pkg::OP_CMOV: begin
            if (b != 0) n_em_result = a;
            else n_em_word = fsp_pkg::NOOP_WORD;
          end
          fsp_pkg::OP_LW, fsp_pkg::OP_SW: n_em_result = a + sext_off;
          fsp_pkg::OP_BEQ: n_em_result = (a == b) ? 32'd1 : 32'd0;
          default: ;
        endcase
        // Memory stage works on the old execute/memory register.
        wb_src = mw_value;
        case (em_word[24:22])
          fsp_pkg::OP_ADD, fsp_pkg::OP_NAND, fsp_pkg::OP_CMOV: mw_value = em_result;
          fsp_pkg::OP_LW: mw_value = data_word(em_result);
          fsp_pkg::OP_SW: begin
            r.st_valid = 1;
            r.st_addr = em_result[15:0];
            r.st_value = em_b;
            dmem[int'(em_result[15:0])] = em_b;
          end
          default: ;
        endcase
        if (em_word[24:22] == fsp_pkg::OP_BEQ && em_result == 32'd1) begin
          n_fd_word = fsp_pkg::NOOP_WORD;
          n_de_word = fsp_pkg::NOOP_WORD;
          n_em_word = fsp_pkg::NOOP_WORD;
          n_pc = em_target;
        end
        d = dest_reg(mw_word, 1);
        if (d != 4'd8) begin
          rf[d[2:0]] = wb_src;
          r.wb_valid = 1;
          r.wb_reg = d[2:0];
          r.wb_value = wb_src;
        end
        we_word = mw_word;
        we_value = wb_src;
        mw_word = em_word;
        em_target = de_pc + sext_off[15:0];
        em_b = b;
        em_word = n_em_word;
        em_result = n_em_result;
        de_a = n_de_a;
        de_b = n_de_b;
        de_off = fd_word[15:0];
        de_pc = fd_pc;
        de_word = n_de_word;
        fd_word = n_fd_word;
        fd_pc = n_fd_pc;
        pc = n_pc;
      end
      r.cycle_count = cycles;
      r.pc = pc;
      if (r.wb_valid) writebacks++;
      if (r.st_valid) stores++;
      pending.push_back(r);
    endfunction

    function void check(core_result_t got);
      core_result_t want;
      if (pending.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.halted !== want.halted) begin
        $error("halted: expected %0d, got %0d", want.halted, got.halted); errors++;
      end
      if (got.cycle_count !== want.cycle_count) begin
        $error("cycle_count: expected %0d, got %0d", want.cycle_count, got.cycle_count);
        errors++;
      end
      if (got.pc !== want.pc) begin
        $error("program_counter_out: expected %h, got %h", want.pc, got.pc); errors++;
      end
      if (got.wb_valid !== want.wb_valid) begin
        $error("writeback_valid: expected %0d, got %0d", want.wb_valid, got.wb_valid);
        errors++;
      end
      if (got.wb_reg !== want.wb_reg) begin
        $error("writeback_register: expected %0d, got %0d", want.wb_reg, got.wb_reg);
        errors++;
      end
      if (got.wb_value !== want.wb_value) begin
        $error("writeback_value: expected %h, got %h", want.wb_value, got.wb_value);
        errors++;
      end
      if (got.st_valid !== want.st_valid) begin
        $error("store_valid: expected %0d, got %0d", want.st_valid, got.st_valid);
        errors++;
      end
      if (got.st_addr !== want.st_addr) begin
        $error("store_address: expected %h, got %h", want.st_addr, got.st_addr); errors++;
      end
      if (got.st_value !== want.st_value) begin
        $error("store_value: expected %h, got %h", want.st_value, got.st_value); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int   steps_sent, loads_sent;
  core_scoreboard sb;

  fsp_in_if  items();
  fsp_out_if results();

  five_stage_pipeline_core dut (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results)
  );

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      results.ready <= calm || ($urandom_range(0, 99) >= 23);
    end
  end

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      sb.check({results.halted, results.cycle_count, results.program_counter_out,
                results.writeback_valid, results.writeback_register,
                results.writeback_value, results.store_valid, results.store_address,
                results.store_value});
    end
  end

  task automatic send_item(input logic operation, input logic [15:0] addr,
                           input logic [31:0] data);
    items.valid <= 1'b1;
    items.operation <= operation;
    items.load_address <= addr;
    items.load_data <= data;
    do @(posedge clk); while (!items.ready);
    sb.note(operation, addr, data);
    if (operation) steps_sent++;
    else loads_sent++;
    if (!calm && $urandom_range(0, 99) < 23) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] make_word(logic [2:0] op, logic [2:0] ra, logic [2:0] rb,
                                            logic [15:0] low);
    return {7'd0, op, ra, rb, low};
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int unsigned pick;
    w = $urandom;
    pick = $urandom_range(0, 6);
    w[24:22] = (pick == 6) ? 3'd7 : pick[2:0];
    if ($urandom_range(0, 3) != 0) begin
      w[15:0] = 16'($urandom_range(0, 16)) - 16'd8;
    end
    return w;
  endfunction

  // Make sure a step never fetches or loads a word that was never written.
  task automatic step_core();
    if (!sb.imem.exists(int'(sb.pc))) begin
      send_item(1'b0, sb.pc, random_word());
    end
    if (sb.em_word[24:22] == fsp_pkg::OP_LW && !sb.dmem.exists(int'(sb.em_result[15:0]))) begin
      send_item(1'b0, sb.em_result[15:0], $urandom);
    end
    send_item(1'b1, '0, '0);
  endtask

  initial begin
    logic [31:0] prog[12];
    clk = 1'b0;
    rst = 1'b1;
    calm = 1'b0;
    steps_sent = 0;
    loads_sent = 0;
    sb = new();
    items.valid = 1'b0;
    items.operation = 1'b0;
    items.load_address = '0;
    items.load_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    prog[0]  = make_word(fsp_pkg::OP_LW, 3'd0, 3'd1, 16'hFFFF);
    prog[1]  = make_word(fsp_pkg::OP_ADD, 3'd1, 3'd1, 16'd2);
    prog[2]  = make_word(fsp_pkg::OP_NAND, 3'd2, 3'd1, 16'd3);
    prog[3]  = make_word(fsp_pkg::OP_CMOV, 3'd1, 3'd0, 16'd4);
    prog[4]  = make_word(fsp_pkg::OP_CMOV, 3'd1, 3'd2, 16'd5);
    prog[5]  = make_word(fsp_pkg::OP_SW, 3'd0, 3'd3, 16'h8000);
    prog[6]  = make_word(fsp_pkg::OP_ADD, 3'd1, 3'd1, 16'd0);
    prog[7]  = make_word(fsp_pkg::OP_ADD, 3'd0, 3'd0, 16'd6);
    prog[8]  = make_word(fsp_pkg::OP_BEQ, 3'd0, 3'd0, 16'd2);
    prog[9]  = 32'hFE00_0000 | make_word(3'd7, 3'd7, 3'd7, 16'hFFFF);
    prog[10] = make_word(fsp_pkg::OP_ADD, 3'd7, 3'd7, 16'd7);
    prog[11] = make_word(fsp_pkg::OP_BEQ, 3'd1, 3'd0, 16'hFFF8);
    send_item(1'b0, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(1'b0, 16'h8000, 32'h8000_0000);
    foreach (prog[k]) send_item(1'b0, 16'(k), prog[k]);
    repeat (10) step_core();

    for (int i = 0; i < 340; i++) begin
      calm = (i >= 130 && i < 190);
      if ($urandom_range(0, 99) < 25) begin
        if ($urandom_range(0, 1) == 0) send_item(1'b0, sb.pc + 16'($urandom_range(0, 6)),
                                                 random_word());
        else send_item(1'b0, 16'($urandom), $urandom);
      end else begin
        step_core();
      end
    end
    calm = 1'b0;

    // Finish with a halt, then confirm the core stays frozen.
    for (int k = 0; k < 60 && sb.mw_word[24:22] != fsp_pkg::OP_HALT; k++) begin
      if (!sb.imem.exists(int'(sb.pc)) ||
          sb.imem[int'(sb.pc)][24:22] != fsp_pkg::OP_HALT) begin
        send_item(1'b0, sb.pc, make_word(fsp_pkg::OP_HALT, 3'd0, 3'd0, 16'd0));
      end
      step_core();
    end
    repeat (3) send_item(1'b1, '0, '0);
    send_item(1'b0, 16'h0001, 32'hFFFF_FFFF);
    items.valid <= 1'b0;

    for (int k = 0; k < 10000 && sb.pending.size() != 0; k++) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Ran %0d steps and %0d program loads; saw %0d register writes and %0d stores.",
             steps_sent, loads_sent, sb.writebacks, sb.stores);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
